[hw/rtl/vector_axis_angle_rotate_macros.svh]
// Assertion macros used by the top level of the axis-angle rotation RTL.
`ifndef VECTOR_AXIS_ANGLE_ROTATE_MACROS_SVH
`define VECTOR_AXIS_ANGLE_ROTATE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define VAAR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vaar: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define VAAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vaar: next-cycle check failed");

`else

`define VAAR_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define VAAR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hw/rtl/vaar_pkg.sv]
// Types, constants and rounding helpers of the axis-angle rotation block.
package vaar_pkg;

  localparam int VEC_W     = 32;   // Q16.16 component
  localparam int AX_W      = 16;   // Q1.14 axis, sine, cosine
  localparam int IC_W      = 17;   // one minus cosine, Q2.14
  localparam int AA_W      = 32;   // product of two Q1.14 values
  localparam int ENT_W     = 48;   // matrix entry at scale 2^-42
  localparam int MAT_SHIFT = 18;
  localparam int MAT_W     = 30;   // matrix entry at scale 2^-24
  localparam int PROD_W    = MAT_W + VEC_W;
  localparam int SUM_W     = 64;
  localparam int OUT_SHIFT = 24;
  localparam int HI_W      = SUM_W - OUT_SHIFT;
  localparam int ONE_Q14   = 16384;
  localparam int DIAG_SH   = 28;   // cosine on the diagonal, Q1.14 -> 2^-42
  localparam int SIN_SH    = 14;   // sine cross terms, 2^-28 -> 2^-42

  typedef logic signed [VEC_W-1:0] q16_t;
  typedef logic signed [AX_W-1:0]  q14_t;
  typedef logic signed [IC_W-1:0]  ic_t;
  typedef logic signed [AA_W-1:0]  aa_t;
  typedef logic signed [ENT_W-1:0] ent_t;
  typedef logic signed [MAT_W-1:0] mat_t;

  localparam q16_t Q16_MAX  = 32'sh7FFF_FFFF;
  localparam q16_t Q16_MIN  = 32'sh8000_0000;
  localparam ent_t MAT_HALF = ENT_W'(1) <<< (MAT_SHIFT - 1);
  localparam logic signed [SUM_W-1:0] OUT_HALF = SUM_W'(1) <<< (OUT_SHIFT - 1);

  typedef struct packed {
    q16_t vec_x;
    q16_t vec_y;
    q16_t vec_z;
    q14_t axis_x;
    q14_t axis_y;
    q14_t axis_z;
    q14_t sine_in;
    q14_t cosine_in;
  } in_item_t;

  typedef struct packed {
    mat_t [2:0][2:0] m;   // m[row][col]
    q16_t [2:0]      v;
  } mat_item_t;

  typedef struct packed {
    q16_t rot_x;
    q16_t rot_y;
    q16_t rot_z;
    logic saturated;
  } out_item_t;

  // Round half up from 2^-42 to 2^-24: add half, keep bits 47:18 (floor).
  function automatic mat_t mat_round(input ent_t e);
    ent_t t;
    t = e + MAT_HALF;
    return mat_t'(t[MAT_SHIFT +: MAT_W]);
  endfunction

endpackage

[hw/rtl/vaar_ifs.sv]
// Valid/ready stream interfaces for the rotation block's input and result channels.
interface vaar_in_if;
  logic            valid;
  logic            ready;
  vaar_pkg::q16_t  vec_x;
  vaar_pkg::q16_t  vec_y;
  vaar_pkg::q16_t  vec_z;
  vaar_pkg::q14_t  axis_x;
  vaar_pkg::q14_t  axis_y;
  vaar_pkg::q14_t  axis_z;
  vaar_pkg::q14_t  sine_in;
  vaar_pkg::q14_t  cosine_in;

  modport source (output valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z,
                  sine_in, cosine_in, input ready);
  modport sink   (input valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z,
                  sine_in, cosine_in, output ready);
endinterface

interface vaar_out_if;
  logic            valid;
  logic            ready;
  vaar_pkg::q16_t  rot_x;
  vaar_pkg::q16_t  rot_y;
  vaar_pkg::q16_t  rot_z;
  logic            saturated;

  modport source (output valid, rot_x, rot_y, rot_z, saturated, input ready);
  modport sink   (input valid, rot_x, rot_y, rot_z, saturated, output ready);
endinterface

[hw/rtl/vaar_matrix.sv]
// Three-stage pipeline that builds the rounded Rodrigues matrix for each item.
module vaar_matrix (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  vaar_pkg::in_item_t    up_item,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output vaar_pkg::mat_item_t   dn_item
);

  // stage 1: axis products, sine products, one minus cosine
  logic              v1_r;
  vaar_pkg::aa_t     aa_xx_r, aa_yy_r, aa_zz_r, aa_xy_r, aa_xz_r, aa_yz_r;
  vaar_pkg::aa_t     sa_x_r, sa_y_r, sa_z_r;
  vaar_pkg::ic_t     ic_r;
  vaar_pkg::q14_t    c1_r;
  vaar_pkg::q16_t    vec1_r [3];

  // stage 2: (1 - c) * a_i * a_j
  logic              v2_r;
  vaar_pkg::ent_t    icaa_xx_r, icaa_yy_r, icaa_zz_r, icaa_xy_r, icaa_xz_r, icaa_yz_r;
  vaar_pkg::aa_t     sa2_x_r, sa2_y_r, sa2_z_r;
  vaar_pkg::q14_t    c2_r;
  vaar_pkg::q16_t    vec2_r [3];

  // stage 3: entries summed and rounded
  logic              v3_r;
  vaar_pkg::mat_item_t mat_r;
  vaar_pkg::mat_item_t mat_nxt;

  logic en1, en2, en3;
  vaar_pkg::ent_t c_term, sx_term, sy_term, sz_term;

  assign en3      = !v3_r || dn_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign up_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= up_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      aa_xx_r   <= vaar_pkg::aa_t'(up_item.axis_x) * vaar_pkg::aa_t'(up_item.axis_x);
      aa_yy_r   <= vaar_pkg::aa_t'(up_item.axis_y) * vaar_pkg::aa_t'(up_item.axis_y);
      aa_zz_r   <= vaar_pkg::aa_t'(up_item.axis_z) * vaar_pkg::aa_t'(up_item.axis_z);
      aa_xy_r   <= vaar_pkg::aa_t'(up_item.axis_x) * vaar_pkg::aa_t'(up_item.axis_y);
      aa_xz_r   <= vaar_pkg::aa_t'(up_item.axis_x) * vaar_pkg::aa_t'(up_item.axis_z);
      aa_yz_r   <= vaar_pkg::aa_t'(up_item.axis_y) * vaar_pkg::aa_t'(up_item.axis_z);
      sa_x_r    <= vaar_pkg::aa_t'(up_item.sine_in) * vaar_pkg::aa_t'(up_item.axis_x);
      sa_y_r    <= vaar_pkg::aa_t'(up_item.sine_in) * vaar_pkg::aa_t'(up_item.axis_y);
      sa_z_r    <= vaar_pkg::aa_t'(up_item.sine_in) * vaar_pkg::aa_t'(up_item.axis_z);
      ic_r      <= vaar_pkg::IC_W'(vaar_pkg::ONE_Q14) - vaar_pkg::IC_W'(up_item.cosine_in);
      c1_r      <= up_item.cosine_in;
      vec1_r[0] <= up_item.vec_x;
      vec1_r[1] <= up_item.vec_y;
      vec1_r[2] <= up_item.vec_z;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      icaa_xx_r <= vaar_pkg::ENT_W'(ic_r) * vaar_pkg::ENT_W'(aa_xx_r);
      icaa_yy_r <= vaar_pkg::ENT_W'(ic_r) * vaar_pkg::ENT_W'(aa_yy_r);
      icaa_zz_r <= vaar_pkg::ENT_W'(ic_r) * vaar_pkg::ENT_W'(aa_zz_r);
      icaa_xy_r <= vaar_pkg::ENT_W'(ic_r) * vaar_pkg::ENT_W'(aa_xy_r);
      icaa_xz_r <= vaar_pkg::ENT_W'(ic_r) * vaar_pkg::ENT_W'(aa_xz_r);
      icaa_yz_r <= vaar_pkg::ENT_W'(ic_r) * vaar_pkg::ENT_W'(aa_yz_r);
      sa2_x_r   <= sa_x_r;
      sa2_y_r   <= sa_y_r;
      sa2_z_r   <= sa_z_r;
      c2_r      <= c1_r;
      vec2_r    <= vec1_r;
    end
  end

  // Cross-product skew part uses the sine terms; diagonal adds cosine.
  always_comb begin
    c_term  = vaar_pkg::ENT_W'(c2_r)    <<< vaar_pkg::DIAG_SH;
    sx_term = vaar_pkg::ENT_W'(sa2_x_r) <<< vaar_pkg::SIN_SH;
    sy_term = vaar_pkg::ENT_W'(sa2_y_r) <<< vaar_pkg::SIN_SH;
    sz_term = vaar_pkg::ENT_W'(sa2_z_r) <<< vaar_pkg::SIN_SH;
    mat_nxt.m[0][0] = vaar_pkg::mat_round(icaa_xx_r + c_term);
    mat_nxt.m[1][1] = vaar_pkg::mat_round(icaa_yy_r + c_term);
    mat_nxt.m[2][2] = vaar_pkg::mat_round(icaa_zz_r + c_term);
    mat_nxt.m[0][1] = vaar_pkg::mat_round(icaa_xy_r - sz_term);
    mat_nxt.m[1][0] = vaar_pkg::mat_round(icaa_xy_r + sz_term);
    mat_nxt.m[0][2] = vaar_pkg::mat_round(icaa_xz_r + sy_term);
    mat_nxt.m[2][0] = vaar_pkg::mat_round(icaa_xz_r - sy_term);
    mat_nxt.m[1][2] = vaar_pkg::mat_round(icaa_yz_r - sx_term);
    mat_nxt.m[2][1] = vaar_pkg::mat_round(icaa_yz_r + sx_term);
    mat_nxt.v[0]    = vec2_r[0];
    mat_nxt.v[1]    = vec2_r[1];
    mat_nxt.v[2]    = vec2_r[2];
  end

  always_ff @(posedge clk) begin
    if (en3) mat_r <= mat_nxt;
  end

  assign dn_valid = v3_r;
  assign dn_item  = mat_r;

endmodule

[hw/rtl/vaar_mac.sv]
// Two-stage matrix-vector multiply, round to Q16.16 and saturate, with output register.
module vaar_mac (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  vaar_pkg::mat_item_t   up_item,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output vaar_pkg::out_item_t   dn_item
);

  logic                            p_valid_r;
  logic signed [vaar_pkg::PROD_W-1:0] prod_r [3][3];

  logic                  out_valid_r;
  vaar_pkg::out_item_t   out_r;
  vaar_pkg::out_item_t   out_nxt;

  logic en_p, en_o;
  logic signed [vaar_pkg::SUM_W-1:0] sum   [3];
  logic signed [vaar_pkg::HI_W-1:0]  hi    [3];
  vaar_pkg::q16_t                    clamp [3];
  logic [2:0]                        clip;

  assign en_o     = !out_valid_r || dn_ready;
  assign en_p     = !p_valid_r || en_o;
  assign up_ready = en_p;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en_p) p_valid_r   <= up_valid;
      if (en_o) out_valid_r <= p_valid_r;
    end
  end

  // nine 30x32 products, one register stage
  always_ff @(posedge clk) begin
    if (en_p) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_r[i][j] <= vaar_pkg::PROD_W'(vaar_pkg::mat_t'(up_item.m[i][j]))
                        * vaar_pkg::PROD_W'(vaar_pkg::q16_t'(up_item.v[j]));
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = vaar_pkg::SUM_W'(prod_r[i][0]) + vaar_pkg::SUM_W'(prod_r[i][1])
             + vaar_pkg::SUM_W'(prod_r[i][2]) + vaar_pkg::OUT_HALF;
      hi[i]  = sum[i][vaar_pkg::SUM_W-1:vaar_pkg::OUT_SHIFT];
      if (hi[i] > vaar_pkg::HI_W'(vaar_pkg::Q16_MAX)) begin
        clamp[i] = vaar_pkg::Q16_MAX;
        clip[i]  = 1'b1;
      end else if (hi[i] < vaar_pkg::HI_W'(vaar_pkg::Q16_MIN)) begin
        clamp[i] = vaar_pkg::Q16_MIN;
        clip[i]  = 1'b1;
      end else begin
        clamp[i] = hi[i][vaar_pkg::VEC_W-1:0];
        clip[i]  = 1'b0;
      end
    end
    out_nxt.rot_x     = clamp[0];
    out_nxt.rot_y     = clamp[1];
    out_nxt.rot_z     = clamp[2];
    out_nxt.saturated = |clip;
  end

  always_ff @(posedge clk) begin
    if (en_o) out_r <= out_nxt;
  end

  assign dn_valid = out_valid_r;
  assign dn_item  = out_r;

endmodule

[hw/rtl/vector_axis_angle_rotate.sv]
// Top level of the axis-angle (Rodrigues) 3D vector rotation block.
//
// Rotates a Q16.16 vector about a Q1.14 axis given the Q1.14 sine and cosine
// of the angle. The axis is used as given (no normalization). Fully pipelined:
// one item is accepted every cycle, while the output is not stalled, through
// five register stages, which follow the multiplier chain: axis products, the
// (1 - cos) scaling, entry rounding, the nine matrix-by-vector products, then
// the three-term sum with rounding and saturation. Every stage has its own
// valid bit and loads when it is empty or its successor loads, so a stall on
// the output fills bubbles first and never drops or repeats an item; in_ready
// is high whenever out_ready is high. Matrix entries are rounded half up to
// 2^-24, results half up to Q16.16, then clamped to the 32-bit range with the
// saturated flag set if any component clipped.
`include "vector_axis_angle_rotate_macros.svh"

module vector_axis_angle_rotate (
  input  logic         clk,
  input  logic         rst_n,
  vaar_in_if.sink      in_ch,
  vaar_out_if.source   out_ch
);

  vaar_pkg::in_item_t  in_item;
  vaar_pkg::mat_item_t mat_item;
  vaar_pkg::out_item_t out_item;
  logic                mat_valid;
  logic                mat_ready;
  logic                sat_on_rail;

  // pack the input channel fields into the item struct
  assign in_item.vec_x     = in_ch.vec_x;
  assign in_item.vec_y     = in_ch.vec_y;
  assign in_item.vec_z     = in_ch.vec_z;
  assign in_item.axis_x    = in_ch.axis_x;
  assign in_item.axis_y    = in_ch.axis_y;
  assign in_item.axis_z    = in_ch.axis_z;
  assign in_item.sine_in   = in_ch.sine_in;
  assign in_item.cosine_in = in_ch.cosine_in;

  // stages 1-3: rotation matrix
  vaar_matrix u_matrix (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_ch.valid),
    .up_ready (in_ch.ready),
    .up_item  (in_item),
    .dn_valid (mat_valid),
    .dn_ready (mat_ready),
    .dn_item  (mat_item)
  );

  // stages 4-5: multiply, round, saturate; stage 5 is the output register
  vaar_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (mat_valid),
    .up_ready (mat_ready),
    .up_item  (mat_item),
    .dn_valid (out_ch.valid),
    .dn_ready (out_ch.ready),
    .dn_item  (out_item)
  );

  assign out_ch.rot_x     = out_item.rot_x;
  assign out_ch.rot_y     = out_item.rot_y;
  assign out_ch.rot_z     = out_item.rot_z;
  assign out_ch.saturated = out_item.saturated;

  // some output component sits at a rail
  assign sat_on_rail = (out_ch.rot_x == vaar_pkg::Q16_MAX) || (out_ch.rot_x == vaar_pkg::Q16_MIN)
                    || (out_ch.rot_y == vaar_pkg::Q16_MAX) || (out_ch.rot_y == vaar_pkg::Q16_MIN)
                    || (out_ch.rot_z == vaar_pkg::Q16_MAX) || (out_ch.rot_z == vaar_pkg::Q16_MIN);

  // a draining output must open the whole stage chain back to the input
  `VAAR_ASSERT_IMPLY(a_ready_chain, clk, rst_n, out_ch.ready, in_ch.ready)

  // a saturated result has at least one component pinned at a rail
  `VAAR_ASSERT_IMPLY(a_sat_rail, clk, rst_n, out_ch.valid && out_ch.saturated, sat_on_rail)

  // pipeline is empty right after reset: no result before any item
  `VAAR_ASSERT_NEXT(a_empty_after_reset, clk, rst_n, !in_ch.valid && !out_ch.valid && $past(!rst_n), !out_ch.valid)

endmodule

[verif/vector_axis_angle_rotate_tb.sv]
// Self-checking testbench for the axis-angle vector rotation block.
module vector_axis_angle_rotate_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Q16.16 one and Q1.14 one, used to write the directed items readably
  localparam int ONE_Q16 = 65536;
  localparam int ONE_Q14 = vaar_pkg::ONE_Q14;
  localparam int N_RANDOM = 1650;
  localparam int SETTLE_CYCLES = 20;   // pipeline is five deep, leave margin

  // How a random item is built
  typedef enum logic [1:0] {
    STIM_UNIT,    // unit axis, consistent sine and cosine
    STIM_RAW,     // axis, sine and cosine each a raw bit pattern
    STIM_RANGE    // axis, sine, cosine uniform over their stated ranges, unrelated
  } stim_kind_e;

  // Receiver ready patterns, each held for a random stretch of cycles
  typedef enum logic [2:0] {
    RX_OPEN,      // always ready
    RX_TOGGLE,    // every other cycle
    RX_COIN,      // random, half the time
    RX_SPARSE,    // random, a quarter of the time
    RX_HOLD       // stalled for the whole stretch
  } rx_mode_e;

  typedef struct {
    vaar_pkg::in_item_t item;
    bit       drain_first;   // hold this item back until all results are out
  } pending_item_t;

  logic clk = 1'b0;
  logic rst_n;

  vaar_in_if  in_if();
  vaar_out_if out_if();

  vector_axis_angle_rotate i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always #5 clk = ~clk;

  pending_item_t       pending_items[$];   // items not yet offered to the block
  vaar_pkg::out_item_t rot_expected[$];    // predicted rotations, oldest first

  int mismatches  = 0;
  int n_accepted  = 0;
  int n_results   = 0;
  int n_saturated = 0;
  int n_drains    = 0;

  logic     in_fire = 1'b0;          // input item taken at the last rising edge
  int       burst_left = 8;
  int       gap_left = 0;
  rx_mode_e rx_mode = RX_OPEN;
  int       rx_left = 0;

  // ---------------------------------------------------------------------------
  // Rodrigues predictor. Matrix entries are built exactly at 2^-42, rounded
  // half up to 2^-24, then each output is the exact three-term sum at 2^-40
  // rounded half up to Q16.16 and clamped to 32 bits. All intermediate values
  // stay well below 2^62, so 64-bit signed arithmetic is exact here.
  // ---------------------------------------------------------------------------
  function automatic vaar_pkg::out_item_t rodrigues_predict(input vaar_pkg::in_item_t it);
    longint              v[3];
    longint              a[3];
    longint              m[3][3];
    longint              sa[3];
    longint              s, c, ic, acc, r;
    vaar_pkg::q16_t      comp[3];
    logic                sat;
    vaar_pkg::out_item_t res;
    sat = 1'b0;
    v[0] = it.vec_x;
    v[1] = it.vec_y;
    v[2] = it.vec_z;
    a[0] = it.axis_x;
    a[1] = it.axis_y;
    a[2] = it.axis_z;
    s = it.sine_in;
    c = it.cosine_in;
    ic = longint'(ONE_Q14) - c;     // one minus cosine, exact in Q2.14
    for (int i = 0; i < 3; i++) begin
      sa[i] = s * a[i] * (longint'(1) <<< vaar_pkg::SIN_SH);
      for (int j = 0; j < 3; j++) begin
        m[i][j] = ic * a[i] * a[j];
        if (i == j) m[i][j] += c * (longint'(1) <<< vaar_pkg::DIAG_SH);
      end
    end
    // skew-symmetric sine part: s * [a]x
    m[0][1] -= sa[2];
    m[1][0] += sa[2];
    m[0][2] += sa[1];
    m[2][0] -= sa[1];
    m[1][2] -= sa[0];
    m[2][1] += sa[0];
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        m[i][j] = (m[i][j] + (longint'(1) <<< (vaar_pkg::MAT_SHIFT - 1)))
                  >>> vaar_pkg::MAT_SHIFT;
    for (int i = 0; i < 3; i++) begin
      acc = m[i][0] * v[0] + m[i][1] * v[1] + m[i][2] * v[2];
      r = (acc + (longint'(1) <<< (vaar_pkg::OUT_SHIFT - 1))) >>> vaar_pkg::OUT_SHIFT;
      if (r > longint'(vaar_pkg::Q16_MAX)) begin
        r = vaar_pkg::Q16_MAX;
        sat = 1'b1;
      end else if (r < longint'(vaar_pkg::Q16_MIN)) begin
        r = vaar_pkg::Q16_MIN;
        sat = 1'b1;
      end
      comp[i] = vaar_pkg::q16_t'(r);
    end
    res.rot_x = comp[0];
    res.rot_y = comp[1];
    res.rot_z = comp[2];
    res.saturated = sat;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch on result %0d, %s: got %0d, expected %0d",
             $realtime, n_results, what, got, want);
    mismatches++;
  endtask

  task automatic add_item(input int vx, input int vy, input int vz,
                          input int ax, input int ay, input int az,
                          input int sn, input int cs, input bit drain);
    pending_item_t p;
    p.item.vec_x     = vaar_pkg::q16_t'(vx);
    p.item.vec_y     = vaar_pkg::q16_t'(vy);
    p.item.vec_z     = vaar_pkg::q16_t'(vz);
    p.item.axis_x    = vaar_pkg::q14_t'(ax);
    p.item.axis_y    = vaar_pkg::q14_t'(ay);
    p.item.axis_z    = vaar_pkg::q14_t'(az);
    p.item.sine_in   = vaar_pkg::q14_t'(sn);
    p.item.cosine_in = vaar_pkg::q14_t'(cs);
    p.drain_first    = drain;
    pending_items.push_back(p);
  endtask

  // Vector component: mostly a full 32-bit pattern scaled down by a random
  // arithmetic shift, so both huge and modest magnitudes show up.
  function automatic int rand_comp();
    int raw;
    raw = int'($urandom);
    if ($urandom_range(0, 3) == 0) return raw;
    return raw >>> $urandom_range(0, 24);
  endfunction

  function automatic int rand_q14_range();
    return int'($urandom_range(0, 2 * ONE_Q14)) - ONE_Q14;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers items at the falling edge. Items go out in bursts with
  // random gaps between them; an item flagged drain_first waits until every
  // predicted result has come back.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !in_fire) begin
      // offered but not taken yet: hold everything
    end else if (gap_left > 0) begin
      in_if.valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_items.size() == 0 ||
                 (pending_items[0].drain_first && rot_expected.size() != 0)) begin
      in_if.valid <= 1'b0;
    end else begin
      in_if.valid     <= 1'b1;
      in_if.vec_x     <= pending_items[0].item.vec_x;
      in_if.vec_y     <= pending_items[0].item.vec_y;
      in_if.vec_z     <= pending_items[0].item.vec_z;
      in_if.axis_x    <= pending_items[0].item.axis_x;
      in_if.axis_y    <= pending_items[0].item.axis_y;
      in_if.axis_z    <= pending_items[0].item.axis_z;
      in_if.sine_in   <= pending_items[0].item.sine_in;
      in_if.cosine_in <= pending_items[0].item.cosine_in;
      if (pending_items[0].drain_first) n_drains++;
      void'(pending_items.pop_front());
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        // a quarter of the bursts run straight into the next one
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // Receiver: ready follows a pattern that is picked anew at random when its stretch runs out.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_e'($urandom_range(0, 4));
        rx_left <= $urandom_range(8, 40);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   out_if.ready <= 1'b1;
        RX_TOGGLE: out_if.ready <= rx_left[0];
        RX_COIN:   out_if.ready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: out_if.ready <= ($urandom_range(0, 3) == 0);
        default:   out_if.ready <= 1'b0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: at each rising edge, an accepted input item gets its prediction
  // queued and an accepted result is checked against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    vaar_pkg::in_item_t  taken;
    vaar_pkg::out_item_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        taken.vec_x     = in_if.vec_x;
        taken.vec_y     = in_if.vec_y;
        taken.vec_z     = in_if.vec_z;
        taken.axis_x    = in_if.axis_x;
        taken.axis_y    = in_if.axis_y;
        taken.axis_z    = in_if.axis_z;
        taken.sine_in   = in_if.sine_in;
        taken.cosine_in = in_if.cosine_in;
        rot_expected.push_back(rodrigues_predict(taken));
        n_accepted++;
      end
      if (out_if.valid && out_if.ready) begin
        if (rot_expected.size() == 0) begin
          report_mismatch("result with nothing pending, rot_x", out_if.rot_x, 0);
        end else begin
          want = rot_expected.pop_front();
          if (out_if.rot_x !== want.rot_x) report_mismatch("rot_x", out_if.rot_x, want.rot_x);
          if (out_if.rot_y !== want.rot_y) report_mismatch("rot_y", out_if.rot_y, want.rot_y);
          if (out_if.rot_z !== want.rot_z) report_mismatch("rot_z", out_if.rot_z, want.rot_z);
          if (out_if.saturated !== want.saturated)
            report_mismatch("saturated", out_if.saturated, want.saturated);
          if (want.saturated) n_saturated++;
        end
        n_results++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    stim_kind_e kind;
    real ux, uy, uz, nrm, theta;
    int  ax, ay, az, sn, cs;

    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.vec_x = '0;
    in_if.vec_y = '0;
    in_if.vec_z = '0;
    in_if.axis_x = '0;
    in_if.axis_y = '0;
    in_if.axis_z = '0;
    in_if.sine_in = '0;
    in_if.cosine_in = '0;
    out_if.ready = 1'b0;

    // directed: all zero, identity, quarter turns about each axis, half turn
    add_item(0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
    add_item(ONE_Q16, 2 * ONE_Q16, -3 * ONE_Q16, 0, 0, ONE_Q14, 0, ONE_Q14, 1'b0);
    add_item(ONE_Q16, 0, 0, 0, 0, ONE_Q14, ONE_Q14, 0, 1'b0);
    add_item(0, ONE_Q16, 0, ONE_Q14, 0, 0, ONE_Q14, 0, 1'b0);
    add_item(0, 0, ONE_Q16, 0, ONE_Q14, 0, ONE_Q14, 0, 1'b0);
    add_item(ONE_Q16, -ONE_Q16, 5 * ONE_Q16, ONE_Q14, 0, 0, 0, -ONE_Q14, 1'b0);
    // full-scale vectors, no clipping under identity or a half turn of max
    add_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, ONE_Q14, 0, ONE_Q14, 1'b0);
    add_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, ONE_Q14, 0, -ONE_Q14, 1'b0);
    // half turn of the most negative component overflows: clipped, flag set
    add_item(32'h8000_0000, 32'h8000_0000, 1, 0, 0, ONE_Q14, 0, -ONE_Q14, 1'b0);
    // raw field extremes, far outside a unit axis
    add_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             -32768, -32768, -32768, -32768, -32768, 1'b0);
    add_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32767, 32767, 32767, 32767, 32767, 1'b0);
    add_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             32767, -32768, 32767, -32768, 32767, 1'b0);
    // axis not unit length, and a zero axis (matrix is just cosine times I)
    add_item(3 * ONE_Q16, -7 * ONE_Q16, ONE_Q16, ONE_Q14, ONE_Q14, ONE_Q14, ONE_Q14, 0, 1'b0);
    add_item(123456, -654321, 777, 0, 0, 0, 0, ONE_Q14, 1'b0);
    // sine and cosine not consistent
    add_item(ONE_Q16, ONE_Q16, ONE_Q16, 0, ONE_Q14, 0, ONE_Q14, ONE_Q14, 1'b0);
    // output exactly half an LSB: rounds toward plus infinity both signs
    add_item(1, -1, 3, 0, 0, 0, 0, ONE_Q14 / 2, 1'b0);
    add_item(-3, 5, -5, 0, 0, 0, 0, ONE_Q14 / 2, 1'b0);
    // matrix entries landing exactly on half of 2^-24
    add_item(32'h7FFF_0001, -123456789, 987654321, 2, 2, -2, 4, -ONE_Q14, 1'b0);
    add_item(-1000000000, 1000000000, -1, -2, 2, 2, -4, -ONE_Q14, 1'b0);

    // random part; the first item and two later ones wait for a full drain
    for (int n = 0; n < N_RANDOM; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: kind = STIM_UNIT;
        6, 7:             kind = STIM_RAW;
        default:          kind = STIM_RANGE;
      endcase
      case (kind)
        STIM_UNIT: begin
          do begin
            ux = $urandom_range(0, 2000) / 1000.0 - 1.0;
            uy = $urandom_range(0, 2000) / 1000.0 - 1.0;
            uz = $urandom_range(0, 2000) / 1000.0 - 1.0;
            nrm = $sqrt(ux * ux + uy * uy + uz * uz);
          end while (nrm < 0.1);
          theta = $urandom_range(0, 62831) / 10000.0;
          ax = int'(ux / nrm * ONE_Q14);
          ay = int'(uy / nrm * ONE_Q14);
          az = int'(uz / nrm * ONE_Q14);
          sn = int'($sin(theta) * ONE_Q14);
          cs = int'($cos(theta) * ONE_Q14);
        end
        STIM_RAW: begin
          ax = int'($urandom);
          ay = int'($urandom);
          az = int'($urandom);
          sn = int'($urandom);
          cs = int'($urandom);
        end
        default: begin
          ax = rand_q14_range();
          ay = rand_q14_range();
          az = rand_q14_range();
          sn = rand_q14_range();
          cs = rand_q14_range();
        end
      endcase
      add_item(rand_comp(), rand_comp(), rand_comp(), ax, ay, az, sn, cs,
               (n == 0) || (n == N_RANDOM / 3) || (n == 2 * N_RANDOM / 3));
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_items.size() != 0 || in_if.valid) @(posedge clk);
    while (rot_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d items (%0d random) and %0d checked results, %0d of them clipped;",
             n_accepted, N_RANDOM, n_results, n_saturated);
    $display("bursty input, changing output stall patterns, %0d full drains, %0d mismatches.",
             n_drains, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run with these gap and stall sizes
  initial begin : watchdog
    #5ms;
    $display("Timeout: %0d items left to send, %0d results outstanding",
             pending_items.size(), rot_expected.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
